// File: src/ps2d_pkg.sv
// ps2d_pkg: shared types, event codes and key maps of the scan code event decoder
// no dependencies
package ps2d_pkg;

    localparam logic [7:0] PREFIX_CODE   = 8'hE0;
    localparam logic [6:0] LSHIFT_CODE   = 7'h2A;
    localparam logic [6:0] RSHIFT_CODE   = 7'h36;
    localparam logic [6:0] SPACE_CODE    = 7'h39;
    localparam logic [6:0] INSERT_CODE   = 7'h52;
    localparam logic [6:0] UP_CODE       = 7'h48;
    localparam logic [6:0] DOWN_CODE     = 7'h50;
    localparam logic [6:0] LEFT_CODE     = 7'h4B;
    localparam logic [6:0] RIGHT_CODE    = 7'h4D;
    localparam logic [6:0] DELETE_CODE   = 7'h53;
    localparam logic [6:0] SPACE_CHAR    = 7'h20;
    localparam int         MAP_SIZE      = 54;
    localparam logic [6:0] MAP_LIMIT     = 7'(MAP_SIZE);

    typedef enum logic [2:0] {
        EV_CHAR   = 3'd0,
        EV_UP     = 3'd1,
        EV_DOWN   = 3'd2,
        EV_LEFT   = 3'd3,
        EV_RIGHT  = 3'd4,
        EV_DELETE = 3'd5,
        EV_INSERT = 3'd6
    } ps2d_kind_t;

    typedef struct packed {
        logic       emit;
        ps2d_kind_t kind;
        logic [6:0] char_code;
        logic       insert_on;
    } ps2d_result_t;

    localparam logic [6:0] PLAIN_MAP [0:MAP_SIZE-1] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08,
        7'h09, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69, 7'h6F,
        7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C,
        7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F
    };

    localparam logic [6:0] SHIFT_MAP [0:MAP_SIZE-1] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08,
        7'h09, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49, 7'h4F,
        7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C,
        7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F
    };

    function automatic logic [6:0] key_char(input logic [6:0] code, input logic shift);
        logic [6:0] ch;
        ch = 7'h00;
        if (code == SPACE_CODE)
        begin
            ch = SPACE_CHAR;
        end
        else if (code < MAP_LIMIT)
        begin
            ch = shift ? SHIFT_MAP[code[5:0]] : PLAIN_MAP[code[5:0]];
        end
        return ch;
    endfunction

endpackage

// File: src/ps2d_decode.sv
// ps2d_decode: keyboard flag registers and the per-byte event decode logic
// depends on ps2d_pkg
module ps2d_decode (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            scan_byte,
    output ps2d_pkg::ps2d_result_t result
);
    import ps2d_pkg::*;

    logic shift_reg,  shift_next;
    logic prefix_reg, prefix_next;
    logic ins_reg,    ins_next;
    logic held_reg,   held_next;
    logic       released;
    logic [6:0] code;

    always_comb
    begin
        released          = scan_byte[7];
        code              = scan_byte[6:0];
        shift_next        = shift_reg;
        prefix_next       = prefix_reg;
        ins_next          = ins_reg;
        held_next         = held_reg;
        result.emit       = 1'b0;
        result.kind       = EV_CHAR;
        result.char_code  = 7'h00;
        if (scan_byte == PREFIX_CODE)
        begin
            prefix_next = 1'b1;
        end
        else if (prefix_reg)
        begin
            prefix_next = 1'b0;
            if (code == INSERT_CODE)
            begin
                if (released)
                begin
                    held_next = 1'b0;
                end
                else if (!held_reg)
                begin
                    held_next   = 1'b1;
                    ins_next    = !ins_reg;
                    result.emit = 1'b1;
                    result.kind = EV_INSERT;
                end
            end
            else if (!released)
            begin
                result.emit = 1'b1;
                unique case (code)
                    UP_CODE:     result.kind = EV_UP;
                    DOWN_CODE:   result.kind = EV_DOWN;
                    LEFT_CODE:   result.kind = EV_LEFT;
                    RIGHT_CODE:  result.kind = EV_RIGHT;
                    DELETE_CODE: result.kind = EV_DELETE;
                    default:     result.emit = 1'b0;
                endcase
            end
        end
        else if (code == LSHIFT_CODE || code == RSHIFT_CODE)
        begin
            shift_next = !released;
        end
        else if (!released)
        begin
            result.emit      = 1'b1;
            result.char_code = key_char(code, shift_reg);
        end
        result.insert_on = ins_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg  <= 1'b0;
            prefix_reg <= 1'b0;
            ins_reg    <= 1'b1;
            held_reg   <= 1'b0;
        end
        else if (step)
        begin
            shift_reg  <= shift_next;
            prefix_reg <= prefix_next;
            ins_reg    <= ins_next;
            held_reg   <= held_next;
        end
    end

endmodule

// File: src/ps2_scancode_event_decoder_unit.sv
// ps2_scancode_event_decoder_unit: top level with input and result registers
// depends on ps2d_pkg and ps2d_decode
// Decodes set-1 keyboard scan bytes into character, cursor, delete and
// insert-toggle events. Each scan byte is captured in an input register,
// decoded combinationally against the shift, prefix and insert flags and
// placed in a result register. An event is offered on the master side from
// the cycle after its byte leaves the input register, so its transaction
// completes at the earliest once the byte has passed both registers. With
// m_tready high one byte is taken every cycle; a held result stalls the input only
// while the waiting byte would produce an event. Bytes that cause no event
// (prefix, break codes, shift keys, repeated insert) yield no output
// transaction and pass even while a result is held. Insert mode is on after
// reset.
module ps2_scancode_event_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] scan_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [2:0] event_kind, [9:3] char_code, [10] insert_on
);
    import ps2d_pkg::*;

    logic         in_valid_reg, in_valid_next;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg, out_valid_next;
    ps2d_result_t out_reg;
    ps2d_result_t dec;
    logic         advance;
    logic         load_out;

    ps2d_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .scan_byte (in_byte_reg),
        .result    (dec)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready || !dec.emit);
    assign load_out = advance && dec.emit;
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next  = s_tvalid ? 1'b1 : (in_valid_reg && !advance);
        if (!s_tready)
        begin
            in_valid_next = in_valid_reg;
        end
        out_valid_next = load_out ? 1'b1 : (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
        if (load_out)
        begin
            out_reg <= dec;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_reg.insert_on, out_reg.char_code, out_reg.kind};

    a_char_only_for_char_events: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_reg.kind != EV_CHAR |-> out_reg.char_code == 7'h00)
        else $error("non-character event carries a character code");

    a_empty_input_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");

    a_result_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result lost or changed");

    a_silent_item_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> advance && in_valid_reg)
        else $error("result loaded without a decoded byte");

endmodule
